[rtl/cht_pkg.sv]
// Package: widths, commands, sequencer states and the bucket hash function of the chained hash table.
`timescale 1ns / 1ps
package cht_pkg;
	localparam int Buckets   = 1024;
	localparam int Nodes     = 1024;
	localparam int KeyBits   = 32;
	localparam int DataBits  = 32;
	localparam int BucketW   = $clog2(Buckets);
	localparam int NodeW     = $clog2(Nodes);
	localparam int LinkW     = NodeW + 1;
	localparam int CountW    = 11;
	localparam int MaskW     = 10;
	localparam logic [LinkW-1:0] NilIdx = LinkW'(Nodes);

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_LOOKUP = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HEAD_RD,
		ST_HEAD_WAIT,
		ST_FREE_RD,
		ST_FREE_WAIT,
		ST_NODE_RD,
		ST_NODE_WAIT,
		ST_UNLINK,
		ST_DONE
	} state_t;

	function automatic logic [BucketW-1:0] bucket_of(input logic [KeyBits-1:0] key,
			input logic [MaskW-1:0] mask);
		logic [KeyBits-1:0] h;
		h = (key ^ (key >> 2) ^ (key >> 6)) & KeyBits'(mask);
		return BucketW'(h);
	endfunction
endpackage

[rtl/cht_req_if.sv]
// Handshake channel interfaces: request in, result out.
`timescale 1ns / 1ps
interface cht_req_if;
	import cht_pkg::*;
	logic                valid;
	logic                ready;
	logic [1:0]          cmd;
	logic [KeyBits-1:0]  key;
	logic [DataBits-1:0] data;
	modport source (output valid, cmd, key, data, input ready);
	modport sink (input valid, cmd, key, data, output ready);
endinterface

interface cht_rsp_if;
	import cht_pkg::*;
	logic                valid;
	logic                ready;
	logic                ok;
	logic [DataBits-1:0] data_out;
	logic [CountW-1:0]   entry_count;
	modport source (output valid, ok, data_out, entry_count, input ready);
	modport sink (input valid, ok, data_out, entry_count, output ready);
endinterface

[rtl/chained_hash_table_core.sv]
// Top level: chained hash table with bucket head and node memories.
//
// Usage: requests enter on req (cmd, key, data) with valid/ready; one
// result per request leaves on rsp (ok, data_out, entry_count).
// cmd 0 inserts at the chain head, 1 removes the newest match, 2 looks
// up the newest match, 3 does nothing. bucket_mask is written through
// cfg_we/cfg_wdata; the user must write it only while idle, which the block does not enforce.
// One request is worked at a time. An insert reads the bucket head and
// the free-list link; a remove or lookup reads the bucket head, then
// reads the node memory once per chain node visited, and a remove hit
// adds an unlink step. Node memory reads are registered. The next
// request is taken the cycle after the result leaves.
// After reset the block clears the bucket head memory, one entry per
// cycle, with req.ready low. The result sits in an output register;
// while rsp.ready is low, the result holds and no new request is
// taken.
`timescale 1ns / 1ps
module chained_hash_table_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [cht_pkg::MaskW-1:0] cfg_wdata,
	cht_req_if.sink                  req,
	cht_rsp_if.source                rsp
);
	import cht_pkg::*;

	// memories
	logic [LinkW-1:0]    head_mem [Buckets];
	logic [KeyBits-1:0]  key_mem  [Nodes];
	logic [DataBits-1:0] val_mem  [Nodes];
	logic [LinkW-1:0]    link_mem [Nodes];

	state_t state_q, state_d;
	logic [MaskW-1:0]    mask_q;
	logic [1:0]          cmd_q;
	logic [KeyBits-1:0]  key_q;
	logic [DataBits-1:0] data_q;
	logic [BucketW-1:0]  bkt_q;
	logic [LinkW-1:0]    cur_q, prev_q, next_q, alloc_q;
	logic [LinkW-1:0]    fresh_q, free_q;
	logic [CountW-1:0]   count_q;
	logic [LinkW-1:0]    steps_q;
	logic [BucketW-1:0]  clr_q;
	logic                rsp_valid_q, rsp_ok_q;
	logic [DataBits-1:0] rsp_data_q;

	// registered read data
	logic [LinkW-1:0]    head_rd_q;
	logic [KeyBits-1:0]  key_rd_q;
	logic [DataBits-1:0] val_rd_q;
	logic [LinkW-1:0]    link_rd_q;

	// memory port controls
	logic                head_we;
	logic [BucketW-1:0]  head_waddr;
	logic [LinkW-1:0]    head_wdata;
	logic                node_we, link_we;
	logic [NodeW-1:0]    node_waddr, link_waddr, node_raddr;
	logic [LinkW-1:0]    link_wdata;

	logic req_fire;
	assign req_fire  = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE) && !rsp_valid_q;

	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[head_waddr] <= head_wdata;
		end
		head_rd_q <= head_mem[bkt_q];
	end

	always_ff @(posedge clk) begin
		if (node_we) begin
			key_mem[node_waddr] <= key_q;
			val_mem[node_waddr] <= data_q;
		end
		if (link_we) begin
			link_mem[link_waddr] <= link_wdata;
		end
		key_rd_q  <= key_mem[node_raddr];
		val_rd_q  <= val_mem[node_raddr];
		link_rd_q <= link_mem[node_raddr];
	end

	// next state and memory controls
	always_comb begin
		state_d    = state_q;
		head_we    = 1'b0;
		head_waddr = bkt_q;
		head_wdata = NilIdx;
		node_we    = 1'b0;
		link_we    = 1'b0;
		node_waddr = alloc_q[NodeW-1:0];
		link_waddr = alloc_q[NodeW-1:0];
		link_wdata = head_rd_q;
		node_raddr = cur_q[NodeW-1:0];
		case (state_q)
			ST_CLEAR: begin
				head_we    = 1'b1;
				head_waddr = clr_q;
				if (clr_q == BucketW'(Buckets - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_fire) state_d = ST_HEAD_RD;
			end
			ST_HEAD_RD: begin
				if (cmd_q == CMD_NOP) state_d = ST_DONE;
				else if (cmd_q == CMD_INSERT) state_d = ST_FREE_RD;
				else state_d = ST_HEAD_WAIT;
			end
			ST_FREE_RD: begin
				node_raddr = free_q[NodeW-1:0];
				state_d    = ST_FREE_WAIT;
			end
			ST_FREE_WAIT: begin
				// alloc_q valid here; write node and head if a node was allocated
				if (alloc_q != NilIdx) begin
					node_we    = 1'b1;
					link_we    = 1'b1;
					head_we    = 1'b1;
					head_wdata = alloc_q;
				end
				state_d = ST_DONE;
			end
			ST_HEAD_WAIT: begin
				state_d = ST_NODE_RD;
			end
			ST_NODE_RD: begin
				if (cur_q == NilIdx || steps_q == LinkW'(Nodes)) state_d = ST_DONE;
				else state_d = ST_NODE_WAIT;
			end
			ST_NODE_WAIT: begin
				if (key_rd_q == key_q) begin
					state_d = (cmd_q == CMD_REMOVE) ? ST_UNLINK : ST_DONE;
				end else begin
					state_d = ST_NODE_RD;
				end
			end
			ST_UNLINK: begin
				if (prev_q != NilIdx) begin
					link_we    = 1'b1;
					link_waddr = prev_q[NodeW-1:0];
					link_wdata = next_q;
				end else begin
					head_we    = 1'b1;
					head_wdata = next_q;
				end
				state_d = ST_DONE;
			end
			ST_DONE: begin
				// the freed node links to the old free head
				if (cmd_q == CMD_REMOVE && rsp_ok_q) begin
					link_we    = 1'b1;
					link_waddr = cur_q[NodeW-1:0];
					link_wdata = alloc_q;
				end
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			mask_q      <= MaskW'(Buckets - 1);
			fresh_q     <= '0;
			free_q      <= NilIdx;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			rsp_ok_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) mask_q <= cfg_wdata;
			if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + 1'b1;
				ST_IDLE: begin
					if (req_fire) rsp_ok_q <= 1'b0;
				end
				ST_FREE_WAIT: begin
					if (alloc_q != NilIdx) begin
						if (free_q != NilIdx) free_q <= link_rd_q;
						else fresh_q <= fresh_q + 1'b1;
						count_q  <= count_q + 1'b1;
						rsp_ok_q <= 1'b1;
					end
				end
				ST_NODE_WAIT: begin
					if (key_rd_q == key_q) rsp_ok_q <= 1'b1;
				end
				ST_UNLINK: begin
					if (count_q != '0) count_q <= count_q - 1'b1;
				end
				ST_DONE: begin
					if (cmd_q == CMD_REMOVE && rsp_ok_q) free_q <= cur_q;
					rsp_valid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					cmd_q      <= req.cmd;
					key_q      <= req.key;
					data_q     <= req.data;
					bkt_q      <= bucket_of(req.key, mask_q);
					rsp_data_q <= '0;
				end
			end
			ST_HEAD_RD: begin
				prev_q  <= NilIdx;
				steps_q <= '0;
				if (free_q != NilIdx) alloc_q <= free_q;
				else if (fresh_q != NilIdx) alloc_q <= fresh_q;
				else alloc_q <= NilIdx;
			end
			ST_HEAD_WAIT: cur_q <= head_rd_q;
			ST_NODE_WAIT: begin
				if (key_rd_q == key_q) begin
					next_q  <= link_rd_q;
					alloc_q <= free_q;
					if (cmd_q == CMD_LOOKUP) rsp_data_q <= val_rd_q;
				end else begin
					prev_q  <= cur_q;
					cur_q   <= link_rd_q;
					steps_q <= steps_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.ok          = rsp_ok_q;
	assign rsp.data_out    = rsp_data_q;
	assign rsp.entry_count = count_q;

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CountW'(Nodes)) else $error("entry count overflow");
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp.ready |=> rsp_valid_q) else $error("result dropped");
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !req.ready) else $error("request taken while result waits");
	a_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= LinkW'(Nodes)) else $error("fresh counter overrun");
endmodule

[tb/cht_tb_pkg.sv]
// Testbench package: the shared result record type.
`timescale 1ns / 1ps
package cht_tb_pkg;
	import cht_pkg::*;

	typedef struct packed {
		logic                ok;
		logic [DataBits-1:0] data_out;
		logic [CountW-1:0]   entry_count;
	} cht_result_t;
endpackage

[tb/cht_tb_if.sv]
// Testbench note: the channel interfaces come from the RTL; this file holds the mask port bundle.
`timescale 1ns / 1ps
interface cht_cfg_if;
	import cht_pkg::*;
	logic             we;
	logic [MaskW-1:0] wdata;
	modport source (output we, wdata);
	modport sink (input we, wdata);
endinterface

[tb/cht_checker.sv]
// Checker: shadow hash table predicts each result and compares on the result channel.
`timescale 1ns / 1ps
module cht_checker (
	input  logic   clk,
	input  logic   arst_n,
	cht_cfg_if.sink cfg,
	cht_req_if.sink req,
	cht_rsp_if.sink rsp,
	output int     fail_count,
	output int     pending
);
	import cht_pkg::*;
	import cht_tb_pkg::*;

	logic [MaskW-1:0]    mask_q;
	logic [LinkW-1:0]    heads [Buckets];
	logic [KeyBits-1:0]  keys  [Nodes];
	logic [DataBits-1:0] vals  [Nodes];
	logic [LinkW-1:0]    links [Nodes];
	logic [LinkW-1:0]    fresh_idx, free_head;
	logic [CountW-1:0]   live_entries;
	cht_result_t         expected_results[$];

	// Apply one request to the shadow table and return its result
	function automatic cht_result_t apply_request(logic [1:0] op, logic [KeyBits-1:0] k,
			logic [DataBits-1:0] d);
		cht_result_t r;
		logic [BucketW-1:0] b;
		logic [LinkW-1:0] n, prev, nn;
		int steps;
		r = '0;
		b = BucketW'((k ^ (k >> 2) ^ (k >> 6)) & KeyBits'(mask_q));
		case (op)
			CMD_INSERT: begin
				nn = NilIdx;
				if (free_head < NilIdx) begin
					nn = free_head;
					free_head = links[nn[NodeW-1:0]];
				end else if (fresh_idx < NilIdx) begin
					nn = fresh_idx;
					fresh_idx++;
				end
				if (nn < NilIdx) begin
					keys[nn[NodeW-1:0]] = k;
					vals[nn[NodeW-1:0]] = d;
					links[nn[NodeW-1:0]] = heads[b];
					heads[b] = nn;
					live_entries++;
					r.ok = 1'b1;
				end
			end
			CMD_REMOVE, CMD_LOOKUP: begin
				prev = NilIdx;
				n = heads[b];
				for (steps = 0; n < NilIdx && steps < Nodes; steps++) begin
					if (keys[n[NodeW-1:0]] == k) begin
						r.ok = 1'b1;
						if (op == CMD_LOOKUP) r.data_out = vals[n[NodeW-1:0]];
						else begin
							if (prev < NilIdx) links[prev[NodeW-1:0]] = links[n[NodeW-1:0]];
							else heads[b] = links[n[NodeW-1:0]];
							links[n[NodeW-1:0]] = free_head;
							free_head = n;
							if (live_entries > 0) live_entries--;
						end
						break;
					end
					prev = n;
					n = links[n[NodeW-1:0]];
				end
			end
			default: ;
		endcase
		r.entry_count = live_entries;
		return r;
	endfunction

	// Track requests and compare results
	always @(posedge clk or negedge arst_n) begin
		cht_result_t got, want;
		int errs;
		errs = 0;
		if (!arst_n) begin
			mask_q = '1;
			foreach (heads[i]) heads[i] = NilIdx;
			fresh_idx = '0;
			free_head = NilIdx;
			live_entries = '0;
			expected_results.delete();
			fail_count <= 0;
		end else begin
			if (cfg.we) mask_q = cfg.wdata;
			if (req.valid && req.ready)
				expected_results.push_back(apply_request(req.cmd, req.key, req.data));
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.ok, rsp.data_out, rsp.entry_count};
				if (expected_results.size() == 0) begin
					$error("unexpected result ok=%0d data_out=%h entry_count=%0d",
						got.ok, got.data_out, got.entry_count);
					errs++;
				end else begin
					want = expected_results.pop_front();
					if (got.ok !== want.ok) begin
						$error("ok: expected %0d, got %0d", want.ok, got.ok);
						errs++;
					end
					if (got.data_out !== want.data_out) begin
						$error("data_out: expected %h, got %h", want.data_out, got.data_out);
						errs++;
					end
					if (got.entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, got %0d",
							want.entry_count, got.entry_count);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
		end
		pending = expected_results.size();
	end
endmodule

[tb/chained_hash_table_core_test.sv]
// Testbench top: clock, reset, request stimulus, mask writes and verdict.
`timescale 1ns / 1ps
module chained_hash_table_core_test;
	import cht_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count, pending;
	int   cycle_count = 0;
	bit   hold_off = 1'b0;
	logic [KeyBits-1:0] key_pool[$];

	cht_req_if req ();
	cht_rsp_if rsp ();
	cht_cfg_if cfg ();

	chained_hash_table_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg.we),
		.cfg_wdata(cfg.wdata),
		.req      (req),
		.rsp      (rsp)
	);

	cht_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req       (req),
		.rsp       (rsp),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always #5 clk = ~clk;

	// Timeout watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("chained_hash_table_core verification failed");
			$finish;
		end
	end

	// Result-side stall pattern, with one long hold-off on request
	always @(posedge clk) begin
		int r;
		r = $urandom_range(0, 99);
		if (hold_off) rsp.ready <= 1'b0;
		else if (cycle_count % 300 < 100) rsp.ready <= 1'b1;
		else rsp.ready <= (r < 65);
	end

	// Send one request, holding valid until accepted; random gaps between bursts
	task automatic send_request(logic [1:0] op, logic [KeyBits-1:0] k, logic [DataBits-1:0] d);
		req.valid <= 1'b1;
		req.cmd <= op;
		req.key <= k;
		req.data <= d;
		do @(posedge clk); while (!req.ready);
		if ($urandom_range(0, 5) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic go_idle();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_mask(logic [MaskW-1:0] m);
		cfg.we <= 1'b1;
		cfg.wdata <= m;
		@(posedge clk);
		cfg.we <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly keys already inserted, so removes and lookups hit
	function automatic logic [KeyBits-1:0] pick_key();
		if (key_pool.size() != 0 && $urandom_range(0, 3) != 0)
			return key_pool[$urandom_range(0, key_pool.size() - 1)];
		return $urandom();
	endfunction

	task automatic random_phase(int count, int key_span);
		logic [1:0] op;
		logic [KeyBits-1:0] k;
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			op = (r < 40) ? CMD_INSERT : (r < 70) ? CMD_REMOVE : (r < 97) ? CMD_LOOKUP : CMD_NOP;
			k = (key_span > 0) ? KeyBits'($urandom_range(0, key_span)) : pick_key();
			if (op == CMD_INSERT) key_pool.push_back(k);
			send_request(op, k, $urandom());
		end
	endtask

	initial begin
		req.valid = 1'b0;
		req.cmd = '0;
		req.key = '0;
		req.data = '0;
		cfg.we = 1'b0;
		cfg.wdata = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, every command, shadowing, no-op
		send_request(CMD_LOOKUP, 32'h0, 32'h0);
		send_request(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0);
		send_request(CMD_INSERT, 32'h0, 32'hFFFF_FFFF);
		send_request(CMD_INSERT, 32'hFFFF_FFFF, 32'h0);
		send_request(CMD_INSERT, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
		send_request(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0);
		send_request(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0);
		send_request(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h1234_5678);
		send_request(CMD_LOOKUP, 32'h0, 32'h0);
		send_request(CMD_NOP, 32'h5555_AAAA, 32'hFFFF_FFFF);
		send_request(CMD_REMOVE, 32'h0, 32'h0);
		send_request(CMD_INSERT, 32'h0, 32'h1111_1111);
		go_idle();

		// Small table: long chains, many collisions
		write_mask(10'd0);
		random_phase(60, 40);
		go_idle();
		write_mask(10'd3);
		random_phase(60, 200);
		go_idle();

		// Long receiver hold-off so the block backs up
		fork
			begin
				hold_off = 1'b1;
				repeat (200) @(posedge clk);
				hold_off = 1'b0;
			end
			random_phase(20, 0);
		join
		go_idle();

		// Full mask; then a burst of back-to-back inserts
		write_mask(10'd1023);
		random_phase(150, 0);
		go_idle();
		write_mask(10'd7);
		for (int i = 0; i < 20; i++) begin
			req.valid <= 1'b1;
			req.cmd <= CMD_INSERT;
			req.key <= $urandom();
			req.data <= $urandom();
			do @(posedge clk); while (!req.ready);
		end
		random_phase(40, 0);
		go_idle();
		write_mask(10'd511);
		random_phase(200, 0);
		go_idle();

		if (fail_count == 0)
			$display("chained_hash_table_core verification clean");
		else
			$display("chained_hash_table_core verification failed");
		$finish;
	end
endmodule
